// ===== src/tcc_pkg.sv =====
package tcc_pkg;

    // Configuration register indexes
    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [7:0]  COLUMNS_RESET = 8'd80;
    localparam logic [7:0]  ROWS_RESET    = 8'd25;
    localparam logic [31:0] COLOR_RESET   = 32'hFFAA_AAAA;

    // Depth of the queue between the byte parser and the cursor engine
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Byte codes recognized by the parser
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_3        = 8'h33;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_6        = 8'h36;
    localparam logic [7:0] CH_M        = 8'h6D;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_command;

    // Work handed from the parser to the cursor engine
    typedef enum logic [1:0] {
        ACT_DRAW    = 2'd0,
        ACT_NEWLINE = 2'd1,
        ACT_TAB     = 2'd2,
        ACT_CLEAR   = 2'd3
    } t_act_kind;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
    } t_in_req;

    typedef struct packed {
        t_command    command;
        logic [7:0]  cell_column;
        logic [7:0]  cell_row;
        logic [7:0]  glyph_code;
        logic [31:0] color;
        logic        last;
    } t_out_res;

    typedef struct packed {
        t_act_kind   kind;
        logic [7:0]  glyph;
        logic [31:0] color;
    } t_action;

    // Eight-entry foreground palette
    function automatic logic [31:0] palette_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'hFF00_0000;
            3'd1:    c = 32'hFFAA_0000;
            3'd2:    c = 32'hFF00_AA00;
            3'd3:    c = 32'hFFAA_5500;
            3'd4:    c = 32'hFF00_00AA;
            3'd5:    c = 32'hFFAA_00AA;
            3'd6:    c = 32'hFF00_AAAA;
            default: c = 32'hFFAA_AAAA;
        endcase
        return c;
    endfunction

endpackage

// ===== src/tcc_front.sv =====
module tcc_front
    import tcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_in_req i_req,
    input  logic    i_full,
    output logic    o_push,
    output t_action o_action
);

    typedef enum logic [2:0] {
        ESC_IDLE    = 3'd0,
        ESC_START   = 3'd1,
        ESC_BRACKET = 3'd2,
        ESC_THREE   = 3'd3,
        ESC_DIGIT   = 3'd4
    } t_esc_phase;

    t_esc_phase  r_phase, n_phase;
    logic [31:0] r_color, n_color;
    logic [7:0]  r_digit, n_digit;
    logic        accept;
    logic        push;
    logic        normal;
    logic [7:0]  b;

    assign accept = i_valid && !i_full;
    assign b      = i_req.char_byte;

    // Escape parsing and byte classification
    always_comb begin
        n_phase  = r_phase;
        n_color  = r_color;
        n_digit  = r_digit;
        push     = 1'b0;
        normal   = 1'b0;
        o_action = '{kind: ACT_DRAW, glyph: b, color: r_color};
        if (i_req.operation) begin
            push     = 1'b1;
            o_action = '{kind: ACT_CLEAR, glyph: 8'd0, color: 32'd0};
        end else begin
            case (r_phase)
                ESC_START: begin
                    n_phase = (b == CH_LBRACKET) ? ESC_BRACKET : ESC_IDLE;
                end
                ESC_BRACKET: begin
                    n_phase = (b == CH_3) ? ESC_THREE : ESC_IDLE;
                end
                ESC_THREE: begin
                    n_digit = b;
                    n_phase = ESC_DIGIT;
                end
                ESC_DIGIT: begin
                    n_phase = ESC_IDLE;
                    if (b == CH_M) begin
                        if (r_digit inside {[CH_0:CH_6]}) begin
                            n_color = palette_color(3'(r_digit - CH_0));
                        end else begin
                            n_color = palette_color(3'd7);
                        end
                    end else begin
                        normal = 1'b1;
                    end
                end
                default: begin
                    n_phase = ESC_IDLE;
                    normal  = 1'b1;
                end
            endcase
            if (normal) begin
                case (b)
                    CH_CR: ;
                    CH_LF: begin
                        push          = 1'b1;
                        o_action.kind = ACT_NEWLINE;
                    end
                    CH_TAB: begin
                        push          = 1'b1;
                        o_action.kind = ACT_TAB;
                    end
                    CH_ESC: begin
                        n_phase = ESC_START;
                    end
                    default: begin
                        push = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_push = accept && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ESC_IDLE;
            r_color <= COLOR_RESET;
            r_digit <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_color <= n_color;
            r_digit <= n_digit;
        end
    end

endmodule

// ===== src/tcc_queue.sv =====
module tcc_queue
    import tcc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_action i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_action o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_action            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");

endmodule

// ===== src/tcc_back.sv =====
module tcc_back
    import tcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_columns,
    input  logic [7:0] i_rows,
    input  logic       i_empty,
    input  t_action    i_action,
    output logic       o_pop,
    output logic       o_valid,
    output t_out_res   o_res,
    input  logic       i_stall
);

    logic       r_valid, n_valid;
    t_out_res   r_res, n_res;
    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;
    logic       r_pend, n_pend;

    logic [7:0] nc, nr;
    logic       slot_free;
    logic [8:0] col_inc, col_tab, row_inc;
    logic       row_over;
    logic [7:0] row_next;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Cursor movement and result generation
    always_comb begin
        nc        = (i_columns == 8'd0) ? 8'd1 : i_columns;
        nr        = (i_rows == 8'd0) ? 8'd1 : i_rows;
        slot_free = !r_valid || !i_stall;
        col_inc   = {1'b0, r_col} + 9'd1;
        col_tab   = {1'b0, r_col} + 9'd4;
        row_inc   = {1'b0, r_row} + 9'd1;
        row_over  = (row_inc >= {1'b0, nr});
        row_next  = row_over ? (nr - 8'd1) : row_inc[7:0];

        o_pop   = 1'b0;
        n_valid = r_valid && i_stall;
        n_res   = '0;
        n_col   = r_col;
        n_row   = r_row;
        n_pend  = r_pend;

        if (slot_free) begin
            if (r_pend) begin
                // scroll that follows a wrapping draw
                n_valid       = 1'b1;
                n_res.command = CMD_SCROLL;
                n_res.last    = 1'b1;
                n_pend        = 1'b0;
            end else if (!i_empty) begin
                o_pop = 1'b1;
                case (i_action.kind)
                    ACT_CLEAR: begin
                        n_valid       = 1'b1;
                        n_res.command = CMD_CLEAR;
                        n_res.last    = 1'b1;
                        n_col         = 8'd0;
                        n_row         = 8'd0;
                    end
                    ACT_DRAW: begin
                        n_valid           = 1'b1;
                        n_res.command     = CMD_DRAW;
                        n_res.cell_column = r_col;
                        n_res.cell_row    = r_row;
                        n_res.glyph_code  = i_action.glyph;
                        n_res.color       = i_action.color;
                        if (col_inc >= {1'b0, nc}) begin
                            n_col      = 8'd0;
                            n_row      = row_next;
                            n_pend     = row_over;
                            n_res.last = !row_over;
                        end else begin
                            n_col      = col_inc[7:0];
                            n_res.last = 1'b1;
                        end
                    end
                    ACT_NEWLINE: begin
                        n_col         = 8'd0;
                        n_row         = row_next;
                        n_valid       = row_over;
                        n_res.command = CMD_SCROLL;
                        n_res.last    = 1'b1;
                    end
                    ACT_TAB: begin
                        if (col_tab >= {1'b0, nc}) begin
                            n_col         = 8'd0;
                            n_row         = row_next;
                            n_valid       = row_over;
                            n_res.command = CMD_SCROLL;
                            n_res.last    = 1'b1;
                        end else begin
                            n_col = col_tab[7:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
            r_col   <= 8'd0;
            r_row   <= 8'd0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    // Output payload holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_res <= n_res;
        end
    end

    a_pend_has_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_valid && r_res.command == CMD_DRAW && !r_res.last)
        else $error("pending scroll without its draw in the output register");

    a_not_last_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.last) |-> r_pend)
        else $error("non-final result without a pending scroll");

endmodule

// ===== src/text_console_cursor_control.sv =====
// Character-cell console cursor controller.
// Input channel (i_in_valid / i_in_req / o_in_stall): one request per accepted
// edge, either a byte written to the console or a clear-screen request.
// Output channel (o_out_valid / o_out_res / i_out_stall): draw, scroll and
// clear commands; the last flag marks the final result of each request.
// Configuration: i_cfg_we writes i_cfg_data into the column or row count
// selected by i_cfg_index; user must write only while the block is idle (unchecked).
// Timing: an accepted request enters the queue; its first result is registered
// when popped, and a wrapping draw's scroll is registered as the draw leaves.
// Throughput: one request per cycle while o_in_stall is low; a draw that wraps
// and scrolls holds the single output register for its draw, then its scroll,
// so the cursor engine takes one queue entry per free output slot. Requests that
// cause no result (escape bytes, carriage return, color selection) pass at the same rate.
// A request queue decouples the byte parser from the cursor engine; when the
// receiver stalls, the queue fills and o_in_stall rises.
// Reset (synchronous, active low) homes the cursor, restores light gray,
// leaves escape parsing and sets 80 columns by 25 rows.
module text_console_cursor_control
    import tcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_req    i_in_req,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_res   o_out_res,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic       q_push, q_pop, q_full, q_empty;
    t_action    q_in, q_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = q_full;

    tcc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_req    (i_in_req),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_action (q_in)
    );

    tcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    tcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .i_empty   (q_empty),
        .i_action  (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .o_res     (o_out_res),
        .i_stall   (i_out_stall)
    );

endmodule

// ===== bench/tb_text_console_cursor_control.sv =====
module tb_text_console_cursor_control;
    import tcc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 600;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_MAX    = 10;

    // Foreground palette, entry 0 rightmost
    localparam logic [7:0][31:0] PALETTE = {
        32'hFFAA_AAAA, 32'hFF00_AAAA, 32'hFFAA_00AA, 32'hFF00_00AA,
        32'hFFAA_5500, 32'hFF00_AA00, 32'hFFAA_0000, 32'hFF00_0000
    };

    localparam t_out_res SCROLL_RES = '{CMD_SCROLL, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0};
    localparam t_out_res CLEAR_RES  = '{CMD_CLEAR, 8'd0, 8'd0, 8'd0, 32'd0, 1'b1};

    typedef enum logic [2:0] {
        ESC_IDLE,
        ESC_SAW_ESC,
        ESC_SAW_BRACKET,
        ESC_SAW_THREE,
        ESC_HAVE_DIGIT
    } t_esc_phase;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PULSE
    } t_stall_mode;

    // One line of the directed sequence
    typedef struct packed {
        logic       is_cfg;
        logic [7:0] cols;
        logic [7:0] rows;
        t_in_req    req;
        logic       typed;    // expected results written out in the row
        logic       has_res;  // typed row carries one result
        t_out_res   res;
    } t_dir_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_req    i_in_req;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_res   o_out_res;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    // Console state as the block should hold it
    logic [7:0]  scr_cols;
    logic [7:0]  scr_rows;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [31:0] fg_color;
    t_esc_phase  esc_phase;
    logic [7:0]  held_digit;
    t_out_res    pred_res [2];

    t_out_res    pending_cmds [$];
    t_dir_row    dir_rows [$];
    t_out_res    want;
    t_dir_row    row;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          burst_left;
    int          errors = 0;
    int          cycles = 0;
    int          n;
    int          served;
    int          in_phase;

    text_console_cursor_control dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Column 0 of the next row; appends a scroll when the bottom is passed
    function automatic int new_line(input int cnt);
        int nr;
        nr = (scr_rows == 8'd0) ? 1 : int'(scr_rows);
        cur_col = 8'd0;
        if (int'(cur_row) + 1 >= nr) begin
            cur_row = 8'(nr - 1);
            pred_res[cnt] = SCROLL_RES;
            return cnt + 1;
        end
        cur_row = cur_row + 8'd1;
        return cnt;
    endfunction

    // Advance the console by one request; results land in pred_res
    function automatic int predict_console(input t_in_req r);
        int         cnt;
        int         nc;
        logic [7:0] b;
        bit         plain;
        cnt = 0;
        b = r.char_byte;
        plain = 1'b0;
        nc = (scr_cols == 8'd0) ? 1 : int'(scr_cols);
        if (r.operation) begin
            // clear homes the cursor, escape parsing carries on
            pred_res[0] = CLEAR_RES;
            cur_col = 8'd0;
            cur_row = 8'd0;
            cnt = 1;
        end else begin
            case (esc_phase)
                ESC_SAW_ESC:     esc_phase = (b == CH_LBRACKET) ? ESC_SAW_BRACKET : ESC_IDLE;
                ESC_SAW_BRACKET: esc_phase = (b == CH_3) ? ESC_SAW_THREE : ESC_IDLE;
                ESC_SAW_THREE: begin
                    held_digit = b;
                    esc_phase = ESC_HAVE_DIGIT;
                end
                ESC_HAVE_DIGIT: begin
                    esc_phase = ESC_IDLE;
                    if (b == CH_M) begin
                        fg_color = (held_digit >= CH_0 && held_digit <= CH_6)
                                   ? PALETTE[3'(held_digit - CH_0)] : PALETTE[7];
                    end else begin
                        plain = 1'b1;
                    end
                end
                default: begin
                    esc_phase = ESC_IDLE;
                    plain = 1'b1;
                end
            endcase
        end
        if (plain) begin
            case (b)
                CH_CR: ;  // no effect
                CH_LF: cnt = new_line(cnt);
                CH_TAB: begin
                    if (int'(cur_col) + 4 >= nc) cnt = new_line(cnt);
                    else cur_col = cur_col + 8'd4;
                end
                CH_ESC: esc_phase = ESC_SAW_ESC;
                default: begin
                    pred_res[0] = '{CMD_DRAW, cur_col, cur_row, b, fg_color, 1'b0};
                    cnt = 1;
                    if (int'(cur_col) + 1 >= nc) cnt = new_line(cnt);
                    else cur_col = cur_col + 8'd1;
                end
            endcase
        end
        if (cnt > 0) pred_res[cnt - 1].last = 1'b1;
        return cnt;
    endfunction

    function automatic t_in_req byte_req(input logic [7:0] b);
        t_in_req r;
        r.operation = 1'b0;
        r.char_byte = b;
        return r;
    endfunction

    function automatic t_out_res draw_res(input logic [7:0] col, input logic [7:0] rw,
                                          input logic [7:0] glyph, input logic [31:0] color);
        t_out_res r;
        r = '{CMD_DRAW, col, rw, glyph, color, 1'b1};
        return r;
    endfunction

    // Directed rows: checked by the predictor, or with results typed in
    function automatic t_dir_row req_row(input logic op, input logic [7:0] b);
        t_dir_row d;
        d = '0;
        d.req.operation = op;
        d.req.char_byte = b;
        return d;
    endfunction

    function automatic t_dir_row quiet_row(input logic [7:0] b);
        t_dir_row d;
        d = req_row(1'b0, b);
        d.typed = 1'b1;
        return d;
    endfunction

    function automatic t_dir_row one_row(input logic op, input logic [7:0] b, input t_out_res res);
        t_dir_row d;
        d = req_row(op, b);
        d.typed = 1'b1;
        d.has_res = 1'b1;
        d.res = res;
        return d;
    endfunction

    function automatic t_dir_row cfg_row(input logic [7:0] c, input logic [7:0] r);
        t_dir_row d;
        d = '0;
        d.is_cfg = 1'b1;
        d.cols = c;
        d.rows = r;
        return d;
    endfunction

    // Hand one request over in bursts with random gaps; predicted results are queued
    task automatic push_request(input t_in_req r, input bit predicted, output int cnt);
        int k;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            repeat ($urandom_range(0, 8)) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_req <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cnt = predict_console(r);
        if (predicted) begin
            for (k = 0; k < cnt; k++) pending_cmds.push_back(pred_res[k]);
        end
    endtask

    // Sender pauses until every expected result has come and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] c, input logic [7:0] r);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scr_cols = c;
        scr_rows = r;
    endtask

    // One random request or short sequence; returns how many requests were sent
    task automatic send_random_group(output int sent);
        t_in_req    seq [$];
        int         cnt;
        int         pick;
        logic [7:0] digit;
        logic [7:0] term;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            seq.push_back(byte_req(8'($urandom_range(32, 126))));
        end else if (pick < 50) begin
            seq.push_back(byte_req(8'($urandom_range(0, 255))));
        end else if (pick < 60) begin
            seq.push_back(byte_req(CH_LF));
        end else if (pick < 67) begin
            seq.push_back(byte_req(CH_TAB));
        end else if (pick < 70) begin
            seq.push_back(byte_req(CH_CR));
        end else if (pick < 73) begin
            seq.push_back(t_in_req'{1'b1, 8'($urandom_range(0, 255))});
        end else if (pick < 92) begin
            // color selection, mostly well formed
            digit = ($urandom_range(0, 4) != 0) ? CH_0 + 8'($urandom_range(0, 7))
                                                : 8'($urandom_range(0, 255));
            term = ($urandom_range(0, 4) != 0) ? CH_M : 8'($urandom_range(0, 255));
            seq.push_back(byte_req(CH_ESC));
            seq.push_back(byte_req(CH_LBRACKET));
            seq.push_back(byte_req(CH_3));
            seq.push_back(byte_req(digit));
            seq.push_back(byte_req(term));
        end else begin
            // broken escape
            seq.push_back(byte_req(CH_ESC));
            if ($urandom_range(0, 1) == 0) seq.push_back(byte_req(CH_LBRACKET));
            seq.push_back(byte_req(8'($urandom_range(0, 255))));
        end
        sent = 0;
        foreach (seq[k]) begin
            push_request(seq[k], 1'b1, cnt);
            sent++;
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: cmd %0d col %0d row %0d glyph %h color %h last %b",
                             o_out_res.command, o_out_res.cell_column, o_out_res.cell_row,
                             o_out_res.glyph_code, o_out_res.color, o_out_res.last);
            end else begin
                want = pending_cmds.pop_front();
                if (o_out_res.command !== want.command
                        || o_out_res.cell_column !== want.cell_column
                        || o_out_res.cell_row !== want.cell_row
                        || o_out_res.glyph_code !== want.glyph_code
                        || o_out_res.color !== want.color
                        || o_out_res.last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("mismatch: got cmd %0d col %0d row %0d glyph %h color %h last %b%s%0d%s%0d%s%0d%s%h%s%h%s%b",
                                 o_out_res.command, o_out_res.cell_column, o_out_res.cell_row,
                                 o_out_res.glyph_code, o_out_res.color, o_out_res.last,
                                 "\n          want cmd ", want.command,
                                 " col ", want.cell_column, " row ", want.cell_row,
                                 " glyph ", want.glyph_code, " color ", want.color,
                                 " last ", want.last);
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(4, 60);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
            default:     i_out_stall <= (stall_left % 3 == 0);
        endcase
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[text_console_cursor_control] ERROR");
            $finish;
        end
    end

    initial begin
        burst_left = 0;
        scr_cols = COLUMNS_RESET;
        scr_rows = ROWS_RESET;
        cur_col = 8'd0;
        cur_row = 8'd0;
        fg_color = COLOR_RESET;
        esc_phase = ESC_IDLE;
        held_digit = 8'd0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_COLUMNS;
        i_cfg_data <= 8'd0;

        // Directed sequence, reset geometry 80 x 25
        dir_rows.push_back(one_row(1'b0, "A", draw_res(8'd0, 8'd0, "A", COLOR_RESET)));
        dir_rows.push_back(quiet_row(CH_CR));
        dir_rows.push_back(quiet_row(CH_LF));
        dir_rows.push_back(quiet_row(CH_TAB));
        dir_rows.push_back(req_row(1'b0, 8'hFF));
        dir_rows.push_back(one_row(1'b1, 8'hFF, CLEAR_RES));
        // select green, then draw at home
        dir_rows.push_back(quiet_row(CH_ESC));
        dir_rows.push_back(quiet_row(CH_LBRACKET));
        dir_rows.push_back(quiet_row(CH_3));
        dir_rows.push_back(quiet_row("2"));
        dir_rows.push_back(quiet_row(CH_M));
        dir_rows.push_back(one_row(1'b0, "Z", draw_res(8'd0, 8'd0, "Z", 32'hFF00_AA00)));
        // byte other than bracket after ESC is dropped
        dir_rows.push_back(quiet_row(CH_ESC));
        dir_rows.push_back(quiet_row("x"));
        // missing m: digit dropped, byte drawn normally
        dir_rows.push_back(quiet_row(CH_ESC));
        dir_rows.push_back(quiet_row(CH_LBRACKET));
        dir_rows.push_back(quiet_row(CH_3));
        dir_rows.push_back(quiet_row("5"));
        dir_rows.push_back(req_row(1'b0, "q"));
        // clear inside an escape leaves the escape pending
        dir_rows.push_back(quiet_row(CH_ESC));
        dir_rows.push_back(one_row(1'b1, 8'h00, CLEAR_RES));
        dir_rows.push_back(quiet_row("x"));
        // single cell screen: every move scrolls
        dir_rows.push_back(cfg_row(8'd1, 8'd1));
        dir_rows.push_back(req_row(1'b0, "B"));
        dir_rows.push_back(req_row(1'b0, CH_LF));
        dir_rows.push_back(req_row(1'b0, CH_TAB));
        // zero geometry behaves as one
        dir_rows.push_back(cfg_row(8'd0, 8'd0));
        dir_rows.push_back(req_row(1'b0, "C"));
        dir_rows.push_back(cfg_row(8'd255, 8'd255));
        dir_rows.push_back(req_row(1'b0, CH_TAB));
        dir_rows.push_back(req_row(1'b0, "D"));
        // cursor left outside a shrunken screen
        dir_rows.push_back(cfg_row(8'd2, 8'd2));
        dir_rows.push_back(req_row(1'b0, "E"));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                configure(row.cols, row.rows);
            end else begin
                push_request(row.req, !row.typed, n);
                if (row.typed && row.has_res) pending_cmds.push_back(row.res);
            end
        end

        // Random phases, each with its own screen geometry
        served = 0;
        while (served < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       configure(8'd0, 8'($urandom_range(0, 4)));
                1:       configure(8'd255, 8'd255);
                2:       configure(8'($urandom_range(1, 3)), 8'd1);
                3:       configure(8'($urandom_range(100, 255)), 8'($urandom_range(2, 6)));
                default: configure(8'($urandom_range(2, 16)), 8'($urandom_range(2, 8)));
            endcase
            in_phase = 0;
            while (in_phase < PHASE_ITEMS && served < RANDOM_ITEMS) begin
                send_random_group(n);
                served += n;
                in_phase += n;
                if ($urandom_range(0, 99) == 0) wait_idle();
            end
        end

        wait_idle();
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("[text_console_cursor_control] OK");
        end else begin
            $display("[text_console_cursor_control] ERROR");
        end
        $finish;
    end

endmodule
